[src/aptlv_pkg.sv]
// ----------------------------------------------------------------------------
// Application parameter TLV parser package
// Shared types, tag codes and status codes for the TLV parser.
// ----------------------------------------------------------------------------
package aptlv_pkg;

  // Record tags.
  localparam logic [7:0] TagOrder     = 8'h01;
  localparam logic [7:0] TagSearchVal = 8'h02;
  localparam logic [7:0] TagSearchAtt = 8'h03;
  localparam logic [7:0] TagMaxCount  = 8'h04;
  localparam logic [7:0] TagStartOfs  = 8'h05;
  localparam logic [7:0] TagFilter    = 8'h06;
  localparam logic [7:0] TagFormat    = 8'h07;

  // Result kinds.
  localparam logic KindSearchByte = 1'b0;
  localparam logic KindSummary    = 1'b1;

  // Depth of the result queue.
  localparam int unsigned QDepth = 3;

  // Parser phase within a record.
  typedef enum logic [1:0] {
    PhTag = 2'd0,
    PhLen = 2'd1,
    PhVal = 2'd2
  } phase_e;

  // Block status.
  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StBadLen  = 2'd1,
    StUnknown = 2'd2,
    StTrunc   = 2'd3
  } status_e;

  // One result item.
  typedef struct packed {
    logic        kind;
    logic [7:0]  search_byte;
    status_e     status;
    logic [7:0]  sort_order;
    logic [7:0]  search_attribute;
    logic [63:0] filter_mask;
    logic [7:0]  card_format;
    logic [15:0] max_list_count;
    logic [15:0] list_start_offset;
    logic        search_present;
    logic        end_of_run;
  } result_t;

  // Fixed value length for a tag; zero for the search value, which takes any length.
  function automatic logic [3:0] need_len(input logic [7:0] tag);
    logic [3:0] len;
    len = 4'd0;
    case (tag)
      TagOrder, TagSearchAtt, TagFormat: len = 4'd1;
      TagMaxCount, TagStartOfs:          len = 4'd2;
      TagFilter:                         len = 4'd8;
      default:                           len = 4'd0;
    endcase
    return len;
  endfunction

endpackage

[src/application_parameter_tlv_parser.sv]
// A result enters the result queue as its byte is accepted and is offered on the master
// side once the results ahead of it are taken. One byte per cycle is taken while the
// three-entry queue has room for two; a final search-value byte yields two results.
// Reset: rst_ni clears the parser state and empties the result queue; the parser
// also returns to its reset state after every block-end byte.
// ----------------------------------------------------------------------------
// Application parameter TLV parser
// Parses tag/length/value records one byte per cycle while the result queue has room,
// and reports search-value bytes and a block summary.
module application_parameter_tlv_parser
  import aptlv_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic         s_axis_tlast,   // block_end
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [7:0] search_byte, [9:8] status, [17:10] sort_order, [25:18] search_attribute,
  // [89:26] filter_mask, [97:90] card_format, [113:98] max_list_count,
  // [129:114] list_start_offset, [130] search_present, [135:131] zero
  output logic [135:0] m_axis_tdata,
  output logic         m_axis_tuser,   // kind
  output logic         m_axis_tlast    // end_of_run
);

  // Parser state.
  phase_e      phase_q, phase_d, phase_n;
  logic [7:0]  tag_q, tag_d, tag_n;
  logic [7:0]  left_q, left_d, left_n;
  logic [63:0] acc_q, acc_d, acc_n;
  status_e     err_q, err_d, err_n;
  logic [7:0]  order_q, order_d, order_n;
  logic [7:0]  attr_q, attr_d, attr_n;
  logic [63:0] filter_q, filter_d, filter_n;
  logic [7:0]  format_q, format_d, format_n;
  logic [15:0] count_q, count_d, count_n;
  logic [15:0] offset_q, offset_d, offset_n;
  logic        seen_q, seen_d, seen_n;

  // Result queue.
  result_t     queue_q [QDepth];
  result_t     queue_d [QDepth];
  logic [1:0]  fill_q, fill_d;

  logic        accept;
  logic        pop;
  logic        emit_search;
  logic        is_last;
  logic [7:0]  b;
  logic [3:0]  need;
  logic [1:0]  n_push;
  logic [1:0]  base;
  result_t     res_search;
  result_t     res_summary;
  result_t     res_first;
  status_e     sum_status;

  assign b       = s_axis_tdata;
  assign is_last = s_axis_tlast;
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign pop     = m_axis_tvalid && m_axis_tready;
  assign need    = need_len(tag_q);

  // Next parser state for the offered byte.
  always_comb begin
    phase_n     = phase_q;
    tag_n       = tag_q;
    left_n      = left_q;
    acc_n       = acc_q;
    err_n       = err_q;
    order_n     = order_q;
    attr_n      = attr_q;
    filter_n    = filter_q;
    format_n    = format_q;
    count_n     = count_q;
    offset_n    = offset_q;
    seen_n      = seen_q;
    emit_search = 1'b0;
    if (err_q == StOk) begin
      case (phase_q)
        PhLen: begin
          if (tag_q != TagSearchVal && b != {4'd0, need}) begin
            err_n = StBadLen;
          end else begin
            if (tag_q == TagSearchVal) begin
              seen_n = 1'b1;
            end
            acc_n   = '0;
            left_n  = b;
            phase_n = (b == 8'd0) ? PhTag : PhVal;
          end
        end
        PhVal: begin
          emit_search = (tag_q == TagSearchVal);
          acc_n       = {acc_q[55:0], b};
          left_n      = left_q - 8'd1;
          if (left_n == 8'd0) begin
            phase_n = PhTag;
            case (tag_q)
              TagOrder:     order_n  = acc_n[7:0];
              TagSearchAtt: attr_n   = acc_n[7:0];
              TagMaxCount:  count_n  = acc_n[15:0];
              TagStartOfs:  offset_n = acc_n[15:0];
              TagFilter:    filter_n = acc_n;
              TagFormat:    format_n = acc_n[7:0];
              default:      ;
            endcase
          end
        end
        default: begin
          if (b inside {[TagOrder:TagFormat]}) begin
            tag_n   = b;
            phase_n = PhLen;
          end else begin
            err_n = StUnknown;
          end
        end
      endcase
    end
  end

  // Results caused by the offered byte.
  always_comb begin
    sum_status = err_n;
    if (err_n == StOk && phase_n != PhTag) begin
      sum_status = StTrunc;
    end
    res_search             = '0;
    res_search.kind        = KindSearchByte;
    res_search.search_byte = b;
    res_search.status      = StOk;
    res_search.end_of_run  = !is_last;

    res_summary                   = '0;
    res_summary.kind              = KindSummary;
    res_summary.status            = sum_status;
    res_summary.sort_order        = order_n;
    res_summary.search_attribute  = attr_n;
    res_summary.filter_mask       = filter_n;
    res_summary.card_format       = format_n;
    res_summary.max_list_count    = count_n;
    res_summary.list_start_offset = offset_n;
    res_summary.search_present    = seen_n;
    res_summary.end_of_run        = 1'b1;

    res_first = emit_search ? res_search : res_summary;
    n_push    = {1'b0, emit_search} + {1'b0, is_last};
  end

  // State update: commit on a request, return to reset after the final byte.
  always_comb begin
    phase_d  = phase_q;
    tag_d    = tag_q;
    left_d   = left_q;
    acc_d    = acc_q;
    err_d    = err_q;
    order_d  = order_q;
    attr_d   = attr_q;
    filter_d = filter_q;
    format_d = format_q;
    count_d  = count_q;
    offset_d = offset_q;
    seen_d   = seen_q;
    if (accept) begin
      if (is_last) begin
        phase_d  = PhTag;
        tag_d    = '0;
        left_d   = '0;
        acc_d    = '0;
        err_d    = StOk;
        order_d  = '0;
        attr_d   = '0;
        filter_d = '0;
        format_d = '0;
        count_d  = '0;
        offset_d = '0;
        seen_d   = 1'b0;
      end else begin
        phase_d  = phase_n;
        tag_d    = tag_n;
        left_d   = left_n;
        acc_d    = acc_n;
        err_d    = err_n;
        order_d  = order_n;
        attr_d   = attr_n;
        filter_d = filter_n;
        format_d = format_n;
        count_d  = count_n;
        offset_d = offset_n;
        seen_d   = seen_n;
      end
    end
  end

  // Result queue: shift out at the head, append behind the remaining entries.
  always_comb begin
    queue_d = queue_q;
    if (pop) begin
      queue_d[0] = queue_q[1];
      queue_d[1] = queue_q[2];
    end
    base = fill_q - {1'b0, pop};
    if (accept && n_push != 2'd0) begin
      queue_d[base] = res_first;
      if (n_push == 2'd2) begin
        queue_d[base + 2'd1] = res_summary;
      end
    end
    fill_d = base + (accept ? n_push : 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhTag;
      tag_q    <= '0;
      left_q   <= '0;
      acc_q    <= '0;
      err_q    <= StOk;
      order_q  <= '0;
      attr_q   <= '0;
      filter_q <= '0;
      format_q <= '0;
      count_q  <= '0;
      offset_q <= '0;
      seen_q   <= 1'b0;
      fill_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      tag_q    <= tag_d;
      left_q   <= left_d;
      acc_q    <= acc_d;
      err_q    <= err_d;
      order_q  <= order_d;
      attr_q   <= attr_d;
      filter_q <= filter_d;
      format_q <= format_d;
      count_q  <= count_d;
      offset_q <= offset_d;
      seen_q   <= seen_d;
      fill_q   <= fill_d;
    end
  end

  // Queue entries carry payload only.
  always_ff @(posedge clk_i) begin
    queue_q <= queue_d;
  end

  // Room for two results is needed before a byte is taken.
  assign s_axis_tready = (fill_q <= 2'd1);
  assign m_axis_tvalid = (fill_q != 2'd0);
  assign m_axis_tuser  = queue_q[0].kind;
  assign m_axis_tlast  = queue_q[0].end_of_run;
  assign m_axis_tdata  = {5'd0,
                          queue_q[0].search_present,
                          queue_q[0].list_start_offset,
                          queue_q[0].max_list_count,
                          queue_q[0].card_format,
                          queue_q[0].filter_mask,
                          queue_q[0].search_attribute,
                          queue_q[0].sort_order,
                          queue_q[0].status,
                          queue_q[0].search_byte};

  // The queue never holds more than its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q != 2'd3 || !accept)
    else $error("byte accepted with a full result queue");

  // Once an error is latched, mid-block bytes leave the phase untouched.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !is_last && err_q != StOk |=> phase_q == $past(phase_q) && err_q == $past(err_q))
    else $error("parser state moved after an error");

  // A final byte always leaves the parser in its reset state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_last |=> err_q == StOk && phase_q == PhTag && !seen_q)
    else $error("parser not cleared after block end");

  // A search-value byte result always carries an ok status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KindSearchByte |-> queue_q[0].status == StOk)
    else $error("search byte result with nonzero status");

endmodule

[dv/application_parameter_tlv_parser_test.sv]
// ----------------------------------------------------------------------------
// Application parameter TLV parser testbench
// Feeds parameter blocks byte by byte, starting with a short table of
// hand-built blocks and then random blocks. Most random blocks are well-formed
// records; the rest carry wrong lengths, unknown tags, cut-off records or
// noise. A built-in parser model predicts every search byte and block summary,
// and each result on the master side is checked against it field by field.
// ----------------------------------------------------------------------------
module application_parameter_tlv_parser_test
  import aptlv_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with no transfer on either side before the run is called hung.
  localparam int unsigned IdleLimit = 1000;
  // Bytes to feed in total before the random part stops.
  localparam int unsigned RandomBytes = 1700;

  // One row of the directed table; the status is pinned on rows that end a block.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       pin;
    status_e    status;
  } step_row_t;

  localparam step_row_t DirectedSteps [24] = '{
    // Order, attribute, format and a one-byte search value, all ok.
    '{8'h01, 1'b0, 1'b0, StOk}, '{8'h01, 1'b0, 1'b0, StOk}, '{8'hFF, 1'b0, 1'b0, StOk},
    '{8'h03, 1'b0, 1'b0, StOk}, '{8'h01, 1'b0, 1'b0, StOk}, '{8'h02, 1'b0, 1'b0, StOk},
    '{8'h07, 1'b0, 1'b0, StOk}, '{8'h01, 1'b0, 1'b0, StOk}, '{8'h81, 1'b0, 1'b0, StOk},
    '{8'h02, 1'b0, 1'b0, StOk}, '{8'h01, 1'b0, 1'b0, StOk}, '{8'h5A, 1'b1, 1'b1, StOk},
    // Empty search value ends the block.
    '{8'h02, 1'b0, 1'b0, StOk}, '{8'h00, 1'b1, 1'b1, StOk},
    // Tag zero is unknown.
    '{8'h00, 1'b1, 1'b1, StUnknown},
    // Maximum list count with a three-byte length.
    '{8'h04, 1'b0, 1'b0, StOk}, '{8'h03, 1'b1, 1'b1, StBadLen},
    // Filter cut off after three value bytes.
    '{8'h06, 1'b0, 1'b0, StOk}, '{8'h08, 1'b0, 1'b0, StOk}, '{8'hFF, 1'b0, 1'b0, StOk},
    '{8'hFF, 1'b0, 1'b0, StOk}, '{8'hFF, 1'b1, 1'b1, StTrunc},
    // Unknown tag, then a byte that must be ignored.
    '{8'hFF, 1'b0, 1'b0, StOk}, '{8'h01, 1'b1, 1'b1, StUnknown}
  };

  logic         clk_i;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = 8'h00;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tlast;

  application_parameter_tlv_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Parser model state.
  phase_e      pr_phase   = PhTag;
  logic [7:0]  pr_tag     = 8'h00;
  logic [7:0]  pr_left    = 8'h00;
  logic [63:0] pr_acc     = 64'h0;
  status_e     pr_status  = StOk;
  logic [7:0]  pr_order   = 8'h00;
  logic [7:0]  pr_attr    = 8'h00;
  logic [63:0] pr_filter  = 64'h0;
  logic [7:0]  pr_format  = 8'h00;
  logic [15:0] pr_count   = 16'h0;
  logic [15:0] pr_offset  = 16'h0;
  logic        pr_present = 1'b0;

  result_t     due_results [$];
  logic [7:0]  block_bytes [$];
  int unsigned fault_count   = 0;
  int unsigned bytes_parsed  = 0;
  int unsigned results_seen  = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Required value length of a tag; -1 where any length goes.
  function automatic int fixed_length(input logic [7:0] tag);
    int len;
    case (tag)
      TagOrder, TagSearchAtt, TagFormat: len = 1;
      TagMaxCount, TagStartOfs:          len = 2;
      TagFilter:                         len = 8;
      default:                           len = -1;
    endcase
    return len;
  endfunction

  // Advances the parser model by one accepted byte and queues the results it causes.
  function automatic void parse_byte(input logic [7:0] b, input logic last,
                                     input logic pin, input status_e pin_status);
    result_t r;
    int      need;
    if (pr_status == StOk) begin
      case (pr_phase)
        PhLen: begin
          need = fixed_length(pr_tag);
          if (need >= 0 && int'(b) != need) begin
            pr_status = StBadLen;
          end else begin
            if (pr_tag == TagSearchVal) pr_present = 1'b1;
            pr_acc   = 64'h0;
            pr_left  = b;
            pr_phase = (b == 8'h00) ? PhTag : PhVal;
          end
        end
        PhVal: begin
          // Search bytes go out as they arrive; the summary follows on a final byte.
          if (pr_tag == TagSearchVal) begin
            r             = '0;
            r.kind        = KindSearchByte;
            r.search_byte = b;
            r.end_of_run  = !last;
            due_results.push_back(r);
          end
          pr_acc  = {pr_acc[55:0], b};
          pr_left = pr_left - 8'd1;
          if (pr_left == 8'h00) begin
            case (pr_tag)
              TagOrder:     pr_order  = pr_acc[7:0];
              TagSearchAtt: pr_attr   = pr_acc[7:0];
              TagMaxCount:  pr_count  = pr_acc[15:0];
              TagStartOfs:  pr_offset = pr_acc[15:0];
              TagFilter:    pr_filter = pr_acc;
              TagFormat:    pr_format = pr_acc[7:0];
              default:      ;
            endcase
            pr_phase = PhTag;
          end
        end
        default: begin
          if (b >= TagOrder && b <= TagFormat) begin
            pr_tag   = b;
            pr_phase = PhLen;
          end else begin
            pr_status = StUnknown;
          end
        end
      endcase
    end

    if (last) begin
      r                   = '0;
      r.kind              = KindSummary;
      r.status            = (pr_status == StOk && pr_phase != PhTag) ? StTrunc : pr_status;
      if (pin) r.status   = pin_status;
      r.sort_order        = pr_order;
      r.search_attribute  = pr_attr;
      r.filter_mask       = pr_filter;
      r.card_format       = pr_format;
      r.max_list_count    = pr_count;
      r.list_start_offset = pr_offset;
      r.search_present    = pr_present;
      r.end_of_run        = 1'b1;
      due_results.push_back(r);
      // Every block starts from a clean parser.
      pr_phase   = PhTag;
      pr_tag     = 8'h00;
      pr_left    = 8'h00;
      pr_acc     = 64'h0;
      pr_status  = StOk;
      pr_order   = 8'h00;
      pr_attr    = 8'h00;
      pr_filter  = 64'h0;
      pr_format  = 8'h00;
      pr_count   = 16'h0;
      pr_offset  = 16'h0;
      pr_present = 1'b0;
    end
  endfunction

  // Builds one random block: mostly well-formed records, some broken, some noise.
  function automatic void make_block();
    int         style;
    int         recs;
    int         bad_rec;
    int         tag;
    int         len;
    int         bad_len;
    int         fill;
    int         cut;
    logic [7:0] v;
    block_bytes.delete();
    style = $urandom_range(0, 99);
    if (style < 8) begin
      recs = $urandom_range(1, 6);
      for (int i = 0; i < recs; i++) block_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      recs    = $urandom_range(1, 5);
      bad_rec = $urandom_range(0, recs - 1);
      for (int i = 0; i < recs; i++) begin
        tag = $urandom_range(1, 7);
        len = fixed_length(8'(tag));
        if (len < 0) begin
          len = ($urandom_range(0, 49) == 0) ? $urandom_range(7, 255) : $urandom_range(0, 6);
        end
        if (i == bad_rec && style < 14 && tag != TagSearchVal) begin
          // Wrong length on a fixed-size record.
          bad_len = len;
          while (bad_len == len) bad_len = $urandom_range(0, 255);
          block_bytes.push_back(8'(tag));
          block_bytes.push_back(8'(bad_len));
        end else begin
          if (i == bad_rec && style >= 14 && style < 20) begin
            tag = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(8, 255);
          end
          block_bytes.push_back(8'(tag));
          block_bytes.push_back(8'(len));
          fill = $urandom_range(0, 9);
          for (int k = 0; k < len; k++) begin
            if (fill == 0)      v = 8'h00;
            else if (fill == 1) v = 8'hFF;
            else                v = 8'($urandom_range(0, 255));
            block_bytes.push_back(v);
          end
        end
      end
      // Cut the block short somewhere inside.
      if (style >= 20 && style < 32 && block_bytes.size() > 1) begin
        cut = $urandom_range(1, block_bytes.size() - 1);
        while (block_bytes.size() > cut) void'(block_bytes.pop_back());
      end
    end
  endfunction

  // Offers one byte after an optional gap and feeds the model once it is taken.
  task automatic offer_byte(input logic [7:0] b, input logic last, input logic pin,
                            input status_e pin_status, input int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_parsed++;
    parse_byte(b, last, pin, pin_status);
  endtask

  function automatic void show_field(input string name, input logic [63:0] want,
                                     input logic [63:0] got);
    if (want !== got) $display("  %s: expected %h, got %h", name, want, got);
  endfunction

  // Sender: directed table, then random blocks, then drain and verdict.
  initial begin : byte_source
    bit quiet;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (DirectedSteps[i]) begin
      offer_byte(DirectedSteps[i].data, DirectedSteps[i].last, DirectedSteps[i].pin,
                 DirectedSteps[i].status, $urandom_range(0, 10));
    end
    while (bytes_parsed < RandomBytes) begin
      make_block();
      quiet = ($urandom_range(0, 3) == 0);
      foreach (block_bytes[i]) begin
        offer_byte(block_bytes[i], i == block_bytes.size() - 1, 1'b0, StOk,
                   quiet ? 0 : $urandom_range(0, 10));
      end
    end
    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (fault_count == 0 && due_results.size() == 0) begin
      $display("application_parameter_tlv_parser_test: clean");
    end else begin
      $display("application_parameter_tlv_parser_test: errors");
    end
    $finish;
  end

  // Receiver: random stalls, two long hold-offs, and the result check.
  initial begin : result_sink
    result_t    want;
    result_t    got;
    logic [4:0] pad;
    int         hold;
    bit         quiet;
    quiet = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (results_seen % 40 == 0) quiet = ($urandom_range(0, 2) == 0);
      if (results_seen == 150 || results_seen == 400) hold = 120;
      else hold = quiet ? 0 : $urandom_range(0, 10);
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        for (int i = 0; i < hold; i++) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);

      got.kind              = m_axis_tuser;
      got.search_byte       = m_axis_tdata[7:0];
      got.status            = status_e'(m_axis_tdata[9:8]);
      got.sort_order        = m_axis_tdata[17:10];
      got.search_attribute  = m_axis_tdata[25:18];
      got.filter_mask       = m_axis_tdata[89:26];
      got.card_format       = m_axis_tdata[97:90];
      got.max_list_count    = m_axis_tdata[113:98];
      got.list_start_offset = m_axis_tdata[129:114];
      got.search_present    = m_axis_tdata[130];
      got.end_of_run        = m_axis_tlast;
      pad                   = m_axis_tdata[135:131];

      if (due_results.size() == 0) begin
        if (fault_count < 10) begin
          $display("result %0d arrived with nothing due: kind %b search_byte %h",
                   results_seen, got.kind, got.search_byte);
        end
        fault_count++;
      end else begin
        want = due_results.pop_front();
        if (got !== want || pad !== 5'b0) begin
          if (fault_count < 10) begin
            $display("mismatch on result %0d:", results_seen);
            show_field("kind", 64'(want.kind), 64'(got.kind));
            show_field("search_byte", 64'(want.search_byte), 64'(got.search_byte));
            show_field("status", 64'(want.status), 64'(got.status));
            show_field("sort_order", 64'(want.sort_order), 64'(got.sort_order));
            show_field("search_attribute", 64'(want.search_attribute),
                       64'(got.search_attribute));
            show_field("filter_mask", want.filter_mask, got.filter_mask);
            show_field("card_format", 64'(want.card_format), 64'(got.card_format));
            show_field("max_list_count", 64'(want.max_list_count),
                       64'(got.max_list_count));
            show_field("list_start_offset", 64'(want.list_start_offset),
                       64'(got.list_start_offset));
            show_field("search_present", 64'(want.search_present),
                       64'(got.search_present));
            show_field("end_of_run", 64'(want.end_of_run), 64'(got.end_of_run));
            show_field("padding", 64'h0, 64'(pad));
          end
          fault_count++;
        end
      end
      results_seen++;
    end
  end

  // Watchdog: ends the run when neither side has moved a request for too long.
  initial begin : hang_watch
    int unsigned idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("application_parameter_tlv_parser_test: errors");
    $finish;
  end

endmodule
